>>> rtl/core/deadline_timer_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deadline timer queue check failed");
`define DTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deadline timer queue check failed");
`else
`define DTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DTQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Command and result codes, widths and the remainder unit interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int CMD_W   = 2;
  localparam int KIND_W  = 3;
  localparam int ID_W    = 32;
  localparam int TIME_W  = 63;
  localparam int US_W    = 32;
  localparam int EFF_W   = 34;
  localparam int PROD_W  = 44;
  localparam int DIV_W   = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT_WAIT = 3'd5;

  localparam logic [TIME_W-1:0] IDLE_WAIT_NS = 63'd1000000000000;

  typedef struct packed {
    logic go;
  } dtq_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dtq_div_resp_t;

endpackage

`default_nettype wire

>>> rtl/core/dtq_rem_unit.sv
// ----------------------------------------------------------------------------
// Deadline timer queue remainder unit
// Restoring radix-2 remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_rem_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  dtq_pkg::dtq_div_req_t          req,
  input  wire  [dtq_pkg::DIV_W-1:0]      dividend,
  input  wire  [dtq_pkg::DIV_W-1:0]      divisor,
  output dtq_pkg::dtq_div_resp_t         resp,
  output logic [dtq_pkg::DIV_W-1:0]      rem
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [dtq_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [dtq_pkg::DIV_W-1:0]      dvd_r, dvd_nxt;
  logic [dtq_pkg::DIV_W-1:0]      dvs_r, dvs_nxt;
  logic [dtq_pkg::DIV_W-1:0]      rem_r, rem_nxt;
  logic [dtq_pkg::DIV_W:0]        trial;
  logic [dtq_pkg::DIV_W:0]        diff;

  assign trial = {rem_r, dvd_r[dtq_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = dtq_pkg::DIV_CNT_W'(dtq_pkg::DIV_W);
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // shift in one bit, subtract when it fits
      dvd_nxt = {dvd_r[dtq_pkg::DIV_W-2:0], 1'b0};
      rem_nxt = diff[dtq_pkg::DIV_W] ? trial[dtq_pkg::DIV_W-1:0] : diff[dtq_pkg::DIV_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dtq_pkg::DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign resp.busy = run_r;
  assign resp.done = done_r;
  assign rem       = rem_r;

endmodule

`default_nettype wire

>>> rtl/core/deadline_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Deadline timer queue
// Table of one-shot timers with add, cancel and expiry tick commands.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// in_       start high, busy low       cmd, now_ns, delay_us, jitter_us,
//                                      random_value, cancel_id
// out_      out_valid, one cycle       kind, tmr_id, wait_ns, last
//
// Add: DIV (32-step remainder unit, jitter only), MUL, then ADD.
// Cancel: CRD reads a slot, CCMP compares its id, until a match or the end.
// Tick: one full memory scan (TRD then TCMP per slot) and TDEC per word.
// Table full and cancel of id zero answer from idle; cmd 3 gives no result.
// Reset clears all valid bits and the id counter; no clearing pass.
// Results go out one per strobe and are never held off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deadline_timer_queue_top_defines.svh"

module deadline_timer_queue_top #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [dtq_pkg::CMD_W-1:0]       in_cmd,
  input  wire  [dtq_pkg::TIME_W-1:0]      in_now_ns,
  input  wire  [dtq_pkg::US_W-1:0]        in_delay_us,
  input  wire  [dtq_pkg::US_W-1:0]        in_jitter_us,
  input  wire  [dtq_pkg::US_W-1:0]        in_random_value,
  input  wire  [dtq_pkg::ID_W-1:0]        in_cancel_id,
  output logic                            out_valid,
  output logic [dtq_pkg::KIND_W-1:0]      out_kind,
  output logic [dtq_pkg::ID_W-1:0]        out_tmr_id,
  output logic [dtq_pkg::TIME_W-1:0]      out_wait_ns,
  output logic                            out_last
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TIMER_SLOTS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_CRD  = 4'd4;
  localparam logic [3:0] ST_CCMP = 4'd5;
  localparam logic [3:0] ST_TRD  = 4'd6;
  localparam logic [3:0] ST_TCMP = 4'd7;
  localparam logic [3:0] ST_TDEC = 4'd8;

  logic [3:0]                      state_r, state_nxt;
  logic [TIMER_SLOTS-1:0]          valid_r, valid_nxt;
  logic [dtq_pkg::ID_W-1:0]        last_id_r, last_id_nxt;
  logic [dtq_pkg::TIME_W-1:0]      now_r, now_nxt;
  logic [dtq_pkg::US_W-1:0]        delay_r, delay_nxt;
  logic [dtq_pkg::US_W-1:0]        jitter_r, jitter_nxt;
  logic [dtq_pkg::ID_W-1:0]        cancel_r, cancel_nxt;
  logic [dtq_pkg::EFF_W-1:0]       eff_r, eff_nxt;
  logic [dtq_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [IDX_W-1:0]                slot_r, slot_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  logic                            found_r, found_nxt;
  logic [IDX_W-1:0]                best_idx_r, best_idx_nxt;
  logic [dtq_pkg::TIME_W-1:0]      best_dl_r, best_dl_nxt;
  logic [dtq_pkg::ID_W-1:0]        best_id_r, best_id_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [dtq_pkg::KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic [dtq_pkg::ID_W-1:0]        out_tmr_id_r, out_tmr_id_nxt;
  logic [dtq_pkg::TIME_W-1:0]      out_wait_ns_r, out_wait_ns_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [dtq_pkg::TIME_W-1:0]      dl_mem [TIMER_SLOTS];
  logic [dtq_pkg::ID_W-1:0]        id_mem [TIMER_SLOTS];
  logic [dtq_pkg::TIME_W-1:0]      rd_dl_r;
  logic [dtq_pkg::ID_W-1:0]        rd_id_r;
  logic                            rd_en;
  logic                            mem_we;
  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                cur_idx;

  logic [TIMER_SLOTS-1:0]          free_vec;
  logic [TIMER_SLOTS-1:0]          free_low;
  logic [IDX_W-1:0]                free_idx;
  logic                            any_free;

  dtq_pkg::dtq_div_req_t           div_req;
  dtq_pkg::dtq_div_resp_t          div_resp;
  logic [dtq_pkg::DIV_W-1:0]       div_rem;

  logic [dtq_pkg::EFF_W:0]         eff_sum;
  logic [dtq_pkg::TIME_W:0]        dl_sum;
  logic [dtq_pkg::TIME_W-1:0]      dl_new;
  logic [dtq_pkg::ID_W-1:0]        id_inc;
  logic [dtq_pkg::ID_W-1:0]        id_new;
  logic                            accept;
  logic                            better;
  logic                            expire;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign cur_idx = idx_r[IDX_W-1:0];
  assign rd_addr = cur_idx;

  // lowest free slot
  assign free_vec = ~valid_r;
  assign free_low = free_vec & (~free_vec + 1'b1);
  assign any_free = |free_vec;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (free_low[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  assign div_req.go = accept && (in_cmd == dtq_pkg::CMD_ADD) && any_free &&
                      (in_jitter_us != '0);

  dtq_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (in_random_value),
    .divisor  (in_jitter_us),
    .resp     (div_resp),
    .rem      (div_rem)
  );

  assign eff_sum = (dtq_pkg::EFF_W+1)'(delay_r) + (dtq_pkg::EFF_W+1)'(div_rem) -
                   (dtq_pkg::EFF_W+1)'(jitter_r[dtq_pkg::US_W-1:1]);

  assign dl_sum = {1'b0, now_r} + (dtq_pkg::TIME_W+1)'(prod_r);
  assign dl_new = dl_sum[dtq_pkg::TIME_W] ? '1 : dl_sum[dtq_pkg::TIME_W-1:0];

  assign id_inc = last_id_r + 1'b1;
  assign id_new = (id_inc == '0) ? dtq_pkg::ID_W'(1) : id_inc;

  assign better = valid_r[cur_idx] && (!found_r || (rd_dl_r < best_dl_r));
  assign expire = found_r && (best_dl_r <= now_r);

  assign rd_en  = ((state_r == ST_CRD) || (state_r == ST_TRD)) && (idx_r != SLOT_END);
  assign mem_we = (state_r == ST_ADD);

  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    last_id_nxt      = last_id_r;
    now_nxt          = now_r;
    delay_nxt        = delay_r;
    jitter_nxt       = jitter_r;
    cancel_nxt       = cancel_r;
    eff_nxt          = eff_r;
    prod_nxt         = prod_r;
    slot_nxt         = slot_r;
    idx_nxt          = idx_r;
    found_nxt        = found_r;
    best_idx_nxt     = best_idx_r;
    best_dl_nxt      = best_dl_r;
    best_id_nxt      = best_id_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_tmr_id_nxt   = out_tmr_id_r;
    out_wait_ns_nxt  = out_wait_ns_r;
    out_last_nxt     = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt    = in_now_ns;
          delay_nxt  = in_delay_us;
          jitter_nxt = in_jitter_us;
          cancel_nxt = in_cancel_id;
          slot_nxt   = free_idx;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          unique case (in_cmd)
            dtq_pkg::CMD_ADD: begin
              if (!any_free) begin
                out_valid_nxt    = 1'b1;
                out_kind_nxt     = dtq_pkg::KIND_FULL;
                out_tmr_id_nxt   = '0;
                out_wait_ns_nxt  = '0;
                out_last_nxt     = 1'b1;
              end else if (in_jitter_us == '0) begin
                eff_nxt   = dtq_pkg::EFF_W'(in_delay_us);
                state_nxt = ST_MUL;
              end else begin
                state_nxt = ST_DIV;
              end
            end
            dtq_pkg::CMD_CANCEL: begin
              if (in_cancel_id == '0) begin
                out_valid_nxt    = 1'b1;
                out_kind_nxt     = dtq_pkg::KIND_NOT_FOUND;
                out_tmr_id_nxt   = '0;
                out_wait_ns_nxt  = '0;
                out_last_nxt     = 1'b1;
              end else begin
                state_nxt = ST_CRD;
              end
            end
            dtq_pkg::CMD_TICK: begin
              state_nxt = ST_TRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_resp.done) begin
          // floor a negative delay to one microsecond
          eff_nxt   = eff_sum[dtq_pkg::EFF_W] ? dtq_pkg::EFF_W'(1) :
                                                eff_sum[dtq_pkg::EFF_W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = (dtq_pkg::PROD_W'(eff_r) << 10) - (dtq_pkg::PROD_W'(eff_r) << 4) -
                    (dtq_pkg::PROD_W'(eff_r) << 3);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        valid_nxt[slot_r] = 1'b1;
        last_id_nxt       = id_new;
        out_valid_nxt     = 1'b1;
        out_kind_nxt      = dtq_pkg::KIND_ADDED;
        out_tmr_id_nxt    = id_new;
        out_wait_ns_nxt   = '0;
        out_last_nxt      = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_CRD: begin
        if (idx_r == SLOT_END) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = dtq_pkg::KIND_NOT_FOUND;
          out_tmr_id_nxt   = '0;
          out_wait_ns_nxt  = '0;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          state_nxt = ST_CCMP;
        end
      end
      ST_CCMP: begin
        if (valid_r[cur_idx] && (rd_id_r == cancel_r)) begin
          valid_nxt[cur_idx] = 1'b0;
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = dtq_pkg::KIND_REMOVED;
          out_tmr_id_nxt     = cancel_r;
          out_wait_ns_nxt    = '0;
          out_last_nxt       = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_CRD;
        end
      end
      ST_TRD: begin
        state_nxt = (idx_r == SLOT_END) ? ST_TDEC : ST_TCMP;
      end
      ST_TCMP: begin
        if (better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cur_idx;
          best_dl_nxt  = rd_dl_r;
          best_id_nxt  = rd_id_r;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_TRD;
      end
      ST_TDEC: begin
        out_valid_nxt    = 1'b1;
        out_tmr_id_nxt   = '0;
        out_wait_ns_nxt  = '0;
        if (expire) begin
          // drop the earliest timer and rescan
          valid_nxt[best_idx_r] = 1'b0;
          out_kind_nxt          = dtq_pkg::KIND_EXPIRED;
          out_tmr_id_nxt        = best_id_r;
          out_last_nxt          = 1'b0;
          idx_nxt               = '0;
          found_nxt             = 1'b0;
          state_nxt             = ST_TRD;
        end else begin
          out_kind_nxt    = dtq_pkg::KIND_NEXT_WAIT;
          out_wait_ns_nxt = found_r ? (best_dl_r - now_r) : dtq_pkg::IDLE_WAIT_NS;
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dl_mem[slot_r] <= dl_new;
      id_mem[slot_r] <= id_new;
    end
    if (rd_en) begin
      rd_dl_r <= dl_mem[rd_addr];
      rd_id_r <= id_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      last_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      last_id_r   <= last_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r          <= now_nxt;
    delay_r        <= delay_nxt;
    jitter_r       <= jitter_nxt;
    cancel_r       <= cancel_nxt;
    eff_r          <= eff_nxt;
    prod_r         <= prod_nxt;
    slot_r         <= slot_nxt;
    idx_r          <= idx_nxt;
    found_r        <= found_nxt;
    best_idx_r     <= best_idx_nxt;
    best_dl_r      <= best_dl_nxt;
    best_id_r      <= best_id_nxt;
    out_kind_r     <= out_kind_nxt;
    out_tmr_id_r   <= out_tmr_id_nxt;
    out_wait_ns_r  <= out_wait_ns_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_tmr_id   = out_tmr_id_r;
  assign out_wait_ns  = out_wait_ns_r;
  assign out_last     = out_last_r;

  `DTQ_ASSERT_IMP(a_div_in_seq, clk, rst_n, div_resp.busy || div_resp.done, state_r == ST_DIV)
  `DTQ_ASSERT_IMP(a_add_slot_free, clk, rst_n, state_r == ST_ADD, !valid_r[slot_r])
  `DTQ_ASSERT_IMP(a_expire_more, clk, rst_n, out_valid_r && (out_kind_r == dtq_pkg::KIND_EXPIRED), !out_last_r && busy)
  `DTQ_ASSERT_NXT(a_word_gap, clk, rst_n, out_valid_r && !out_last_r, !out_valid_r)

endmodule

`default_nettype wire

>>> dv/deadline_timer_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Sends add, cancel, tick and undefined commands with random spacing,
// predicts every result word from a private copy of the timer table and
// checks each word field by field as it leaves the block.
// ----------------------------------------------------------------------------

class timer_queue_model;
  localparam int SLOTS = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tmr_id;
    logic [62:0] wait_ns;
    logic        last;
  } answer_t;

  bit          live[SLOTS];
  logic [62:0] due_at[SLOTS];
  logic [31:0] owner_id[SLOTS];
  logic [31:0] last_id;
  answer_t     pending_answers[$];
  int          errors, checked, n_add, n_cancel, n_tick, n_undef, n_expired;

  function new();
    foreach (live[i]) live[i] = 1'b0;
    last_id = '0;
    errors = 0;
    checked = 0;
    n_add = 0;
    n_cancel = 0;
    n_tick = 0;
    n_undef = 0;
    n_expired = 0;
  endfunction

  function void push(logic [2:0] kind, logic [31:0] id, logic [62:0] wns, logic last);
    answer_t a;
    a.kind = kind;
    a.tmr_id = id;
    a.wait_ns = wns;
    a.last = last;
    pending_answers.push_back(a);
  endfunction

  function int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (live[i] && (best < 0 || due_at[i] < due_at[best])) best = i;
    return best;
  endfunction

  function void note_cmd(logic [1:0] cmd, logic [62:0] now, logic [31:0] dly,
                         logic [31:0] jit, logic [31:0] rnd, logic [31:0] cid);
    int          slot, b;
    longint      v;
    logic [63:0] eff, dl;
    slot = -1;
    case (cmd)
      dtq_pkg::CMD_ADD: begin
        n_add++;
        eff = {32'd0, dly};
        if (jit != 0) begin
          v = longint'({32'd0, dly}) - longint'({32'd0, jit >> 1})
            + longint'({32'd0, rnd % jit});
          eff = (v < 0) ? 64'd1 : 64'(v);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!live[i]) slot = i;
        if (slot < 0) begin
          push(dtq_pkg::KIND_FULL, '0, '0, 1'b1);
        end else begin
          dl = {1'b0, now} + eff * 64'd1000;
          if (dl[63]) dl = {1'b0, {63{1'b1}}};
          last_id = last_id + 32'd1;
          if (last_id == 0) last_id = 32'd1;
          live[slot] = 1'b1;
          due_at[slot] = dl[62:0];
          owner_id[slot] = last_id;
          push(dtq_pkg::KIND_ADDED, last_id, '0, 1'b1);
        end
      end
      dtq_pkg::CMD_CANCEL: begin
        n_cancel++;
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && cid != 0 && live[i] && owner_id[i] == cid) slot = i;
        if (slot >= 0) begin
          live[slot] = 1'b0;
          push(dtq_pkg::KIND_REMOVED, cid, '0, 1'b1);
        end else begin
          push(dtq_pkg::KIND_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      dtq_pkg::CMD_TICK: begin
        n_tick++;
        b = earliest_slot();
        while (b >= 0 && due_at[b] <= now) begin
          live[b] = 1'b0;
          push(dtq_pkg::KIND_EXPIRED, owner_id[b], '0, 1'b0);
          b = earliest_slot();
        end
        push(dtq_pkg::KIND_NEXT_WAIT, '0,
             (b < 0) ? dtq_pkg::IDLE_WAIT_NS : due_at[b] - now, 1'b1);
      end
      default: n_undef++;
    endcase
  endfunction

  function void check_word(logic [2:0] kind, logic [31:0] id, logic [62:0] wns,
                           logic last);
    answer_t want;
    checked++;
    if (pending_answers.size() == 0) begin
      errors++;
      $error("unexpected result word: kind %0d tmr_id %0d", kind, id);
      return;
    end
    want = pending_answers.pop_front();
    if (want.kind == dtq_pkg::KIND_EXPIRED) n_expired++;
    if (kind !== want.kind) begin
      errors++;
      $error("kind: expected %0d, got %0d", want.kind, kind);
    end
    if (id !== want.tmr_id) begin
      errors++;
      $error("tmr_id: expected %0d, got %0d", want.tmr_id, id);
    end
    if (wns !== want.wait_ns) begin
      errors++;
      $error("wait_ns: expected %0d, got %0d", want.wait_ns, wns);
    end
    if (last !== want.last) begin
      errors++;
      $error("last: expected %0d, got %0d", want.last, last);
    end
  endfunction
endclass

module deadline_timer_queue_top_tb;

  localparam int                        IDLE_LIMIT   = 4000;
  localparam int                        DRAIN_CYCLES = 80;
  localparam int                        RANDOM_WORDS = 72;
  localparam logic [dtq_pkg::CMD_W-1:0] CMD_UNDEF    = 2'd3;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic [dtq_pkg::CMD_W-1:0]     in_cmd = dtq_pkg::CMD_TICK;
  logic [dtq_pkg::TIME_W-1:0]    in_now_ns = '0;
  logic [dtq_pkg::US_W-1:0]      in_delay_us = '0;
  logic [dtq_pkg::US_W-1:0]      in_jitter_us = '0;
  logic [dtq_pkg::US_W-1:0]      in_random_value = '0;
  logic [dtq_pkg::ID_W-1:0]      in_cancel_id = '0;
  logic                          busy;
  logic                          out_valid;
  logic [dtq_pkg::KIND_W-1:0]    out_kind;
  logic [dtq_pkg::ID_W-1:0]      out_tmr_id;
  logic [dtq_pkg::TIME_W-1:0]    out_wait_ns;
  logic                          out_last;

  timer_queue_model   board;
  int                 idle_cycles = 0;
  bit                 burst = 1'b0;

  deadline_timer_queue_top #(
    .TIMER_SLOTS (16)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_now_ns       (in_now_ns),
    .in_delay_us     (in_delay_us),
    .in_jitter_us    (in_jitter_us),
    .in_random_value (in_random_value),
    .in_cancel_id    (in_cancel_id),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_tmr_id      (out_tmr_id),
    .out_wait_ns     (out_wait_ns),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_word(out_kind, out_tmr_id, out_wait_ns, out_last);
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL deadline_timer_queue_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [62:0] now, logic [31:0] dly,
                           logic [31:0] jit, logic [31:0] rnd, logic [31:0] cid);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_now_ns <= now;
    in_delay_us <= dly;
    in_jitter_us <= jit;
    in_random_value <= rnd;
    in_cancel_id <= cid;
    do @(posedge clk); while (busy);
    board.note_cmd(cmd, now, dly, jit, rnd, cid);
  endtask

  task automatic add_timer(logic [62:0] now, logic [31:0] dly, logic [31:0] jit,
                           logic [31:0] rnd);
    send_word(dtq_pkg::CMD_ADD, now, dly, jit, rnd, $urandom);
  endtask

  task automatic cancel_timer(logic [31:0] cid);
    send_word(dtq_pkg::CMD_CANCEL, rand63(), $urandom, $urandom, $urandom, cid);
  endtask

  task automatic tick_at(logic [62:0] now);
    send_word(dtq_pkg::CMD_TICK, now, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [62:0] walk, now;
    logic [31:0] dly, jit, cid;
    int          sent, pick;
    bit          paused;
    board = new();
    walk = '0;
    sent = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tick_at('0);
    send_word(CMD_UNDEF, rand63(), $urandom, $urandom, $urandom, $urandom);
    cancel_timer('0);
    add_timer('0, '0, '0, $urandom);
    add_timer('0, '0, '1, '0);
    add_timer(63'd100, '1, '1, '1);
    add_timer({63{1'b1}}, 32'd5, '0, $urandom);
    add_timer(63'd1000, 32'd1, 32'd1, '1);
    add_timer('0, '0, '0, $urandom);
    cancel_timer('1);
    cancel_timer(32'd2);
    tick_at('0);
    repeat (14) add_timer(rand63() >> 20, $urandom_range(0, 3000), $urandom_range(0, 50),
                          $urandom);
    tick_at({63{1'b1}});
    drain();

    while (sent < RANDOM_WORDS) begin
      if (sent % 20 == 0) burst = ($urandom_range(0, 2) == 0);
      if (sent == RANDOM_WORDS / 2 && !paused) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick >= 65 && pick < 95) walk = walk + $urandom_range(0, 1500000);
      now = ($urandom_range(0, 49) == 0) ? rand63() : walk;
      if (pick < 45) begin
        dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
        case ($urandom_range(0, 4))
          0, 1:    jit = '0;
          2, 3:    jit = $urandom_range(1, 600);
          default: jit = $urandom;
        endcase
        add_timer(now, dly, jit, $urandom);
        sent++;
      end else if (pick < 65) begin
        case ($urandom_range(0, 6))
          0:       cid = '0;
          1:       cid = $urandom;
          default: cid = board.last_id - $urandom_range(0, 8);
        endcase
        cancel_timer(cid);
        sent++;
      end else if (pick < 95) begin
        tick_at(now);
        sent++;
      end else begin
        send_word(CMD_UNDEF, rand63(), $urandom, $urandom, $urandom, $urandom);
      end
    end
    drain();

    $display("Run covered %0d adds, %0d cancels, %0d ticks and %0d undefined commands,",
             board.n_add, board.n_cancel, board.n_tick, board.n_undef);
    $display("with %0d expiries among %0d result words checked.",
             board.n_expired, board.checked);
    if (board.errors == 0) begin
      $display("PASS deadline_timer_queue_top");
    end else begin
      $display("FAIL deadline_timer_queue_top");
    end
    $finish;
  end
endmodule

>>> deadline_timer_queue_top.f
+incdir+rtl/core
rtl/core/dtq_pkg.sv
rtl/core/dtq_rem_unit.sv
rtl/core/deadline_timer_queue_top.sv
dv/deadline_timer_queue_top_tb.sv
